FILE: rtl/dnp3lfc_pkg.sv
// Shared types, constants and the CRC byte update for the DNP3 link frame checker.
package dnp3lfc_pkg;

  localparam int BLOCK_BYTES  = 16;
  localparam int HEADER_BYTES = 10;
  localparam int LEN_BIAS     = 5;
  localparam int POS_W        = 9;
  localparam int FILL_W       = $clog2(BLOCK_BYTES + 2);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [15:0] CRC_POLY = 16'hA6BC;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MIN_LENGTH  = 2'd2,
    REG_MAX_LENGTH  = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_SYNC      = 3'd2,
    STATUS_LENGTH    = 3'd3,
    STATUS_TRUNCATED = 3'd4,
    STATUS_HDR_CRC   = 3'd5,
    STATUS_DATA_CRC  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] min_length;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic dcrc;
    logic hcrc;
    logic len;
    logic sync;
  } flags_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] control;
    logic [7:0] length;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/dnp3lfc_cfg.sv
// Configuration registers for sync values and the accepted length range.
module dnp3lfc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output dnp3lfc_pkg::cfg_t   cfg
);

  dnp3lfc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= 8'd5;
      cfg_r.sync_second <= 8'd100;
      cfg_r.min_length  <= 8'd5;
      cfg_r.max_length  <= 8'd255;
    end else if (cfg_we) begin
      case (dnp3lfc_pkg::reg_index_t'(cfg_index))
        dnp3lfc_pkg::REG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data;
        dnp3lfc_pkg::REG_SYNC_SECOND: cfg_r.sync_second <= cfg_data;
        dnp3lfc_pkg::REG_MIN_LENGTH:  cfg_r.min_length  <= cfg_data;
        dnp3lfc_pkg::REG_MAX_LENGTH:  cfg_r.max_length  <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/dnp3lfc_core.sv
// Per-byte frame tracking: sync, length, header and block CRC checks and status.
module dnp3lfc_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic                   last_byte,
  input  dnp3lfc_pkg::cfg_t      cfg,
  output dnp3lfc_pkg::result_t   result
);

  localparam int POS_W  = dnp3lfc_pkg::POS_W;
  localparam int FILL_W = dnp3lfc_pkg::FILL_W;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [7:0]          low_r, low_nxt;
  logic [7:0]          len_r, len_nxt;
  logic [7:0]          ctl_r, ctl_nxt;
  logic [7:0]          drem_r, drem_nxt;
  dnp3lfc_pkg::flags_t flags_r, flags_nxt;

  always_comb begin
    logic [POS_W-1:0]    p;
    logic [15:0]         crc;
    logic [FILL_W-1:0]   fill;
    logic [7:0]          low;
    logic [7:0]          len;
    logic [7:0]          ctl;
    logic [7:0]          drem;
    dnp3lfc_pkg::flags_t flags;
    logic [FILL_W-1:0]   blen;
    logic [15:0]         want;
    logic                crc_ok;

    if (first_byte) begin
      p = '0; crc = '0; fill = '0; low = '0; len = '0; ctl = '0; drem = '0; flags = '0;
    end else begin
      p = pos_r; crc = crc_r; fill = fill_r; low = low_r; len = len_r; ctl = ctl_r;
      drem = drem_r; flags = flags_r;
    end

    want   = ~crc;
    crc_ok = (want[7:0] == low) && (want[15:8] == data_byte);
    blen   = (drem > 8'(dnp3lfc_pkg::BLOCK_BYTES)) ? FILL_W'(dnp3lfc_pkg::BLOCK_BYTES)
                                                   : FILL_W'(drem);

    pos_nxt = p; crc_nxt = crc; fill_nxt = fill; low_nxt = low; len_nxt = len;
    ctl_nxt = ctl; drem_nxt = drem; flags_nxt = flags;

    if (p == POS_W'(0)) begin
      if (data_byte != cfg.sync_first) flags_nxt.sync = 1'b1;
    end else if (p == POS_W'(1)) begin
      if (data_byte != cfg.sync_second) flags_nxt.sync = 1'b1;
    end else if (p == POS_W'(2)) begin
      len_nxt = data_byte;
      if (data_byte < cfg.min_length || data_byte > cfg.max_length) flags_nxt.len = 1'b1;
    end else if (p == POS_W'(3)) begin
      ctl_nxt = data_byte;
    end

    if (p < POS_W'(8)) begin
      crc_nxt = dnp3lfc_pkg::crc_byte(crc, data_byte);
    end else if (p == POS_W'(8)) begin
      low_nxt = data_byte;
    end else if (p == POS_W'(9)) begin
      if (!crc_ok) flags_nxt.hcrc = 1'b1;
      crc_nxt  = '0;
      fill_nxt = '0;
      drem_nxt = (len > 8'(dnp3lfc_pkg::LEN_BIAS)) ? len - 8'(dnp3lfc_pkg::LEN_BIAS) : 8'd0;
    end else if (drem != 8'd0) begin
      if (fill < blen) begin
        crc_nxt  = dnp3lfc_pkg::crc_byte(crc, data_byte);
        fill_nxt = fill + FILL_W'(1);
      end else if (fill == blen) begin
        low_nxt  = data_byte;
        fill_nxt = fill + FILL_W'(1);
      end else begin
        if (!crc_ok) flags_nxt.dcrc = 1'b1;
        crc_nxt  = '0;
        fill_nxt = '0;
        drem_nxt = drem - 8'(blen);
      end
    end

    pos_nxt = (p == dnp3lfc_pkg::POS_MAX) ? p : p + POS_W'(1);

    if (pos_nxt < POS_W'(dnp3lfc_pkg::HEADER_BYTES)) begin
      result.status = dnp3lfc_pkg::STATUS_SHORT;
    end else if (flags_nxt.sync) begin
      result.status = dnp3lfc_pkg::STATUS_SYNC;
    end else if (flags_nxt.len) begin
      result.status = dnp3lfc_pkg::STATUS_LENGTH;
    end else if (drem_nxt != 8'd0) begin
      result.status = dnp3lfc_pkg::STATUS_TRUNCATED;
    end else if (flags_nxt.hcrc) begin
      result.status = dnp3lfc_pkg::STATUS_HDR_CRC;
    end else if (flags_nxt.dcrc) begin
      result.status = dnp3lfc_pkg::STATUS_DATA_CRC;
    end else begin
      result.status = dnp3lfc_pkg::STATUS_OK;
    end
    result.control = (result.status == dnp3lfc_pkg::STATUS_OK) ? ctl_nxt : 8'd0;
    result.length  = (result.status == dnp3lfc_pkg::STATUS_OK) ? len_nxt : 8'd0;

    if (last_byte) begin
      pos_nxt = '0; crc_nxt = '0; fill_nxt = '0; low_nxt = '0; len_nxt = '0;
      ctl_nxt = '0; drem_nxt = '0; flags_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= '0;
      fill_r  <= '0;
      low_r   <= '0;
      len_r   <= '0;
      ctl_r   <= '0;
      drem_r  <= '0;
      flags_r <= '0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      fill_r  <= fill_nxt;
      low_r   <= low_nxt;
      len_r   <= len_nxt;
      ctl_r   <= ctl_nxt;
      drem_r  <= drem_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

FILE: rtl/dnp3_link_frame_checker_top.sv
// Top level of the DNP3 link frame checker: input register, frame logic, result register.
//
// Frame bytes enter one per transfer on the in_ channel, with in_first_byte marking the
// start of a frame and in_last_byte marking its end. For each last byte one status
// transfer leaves on the out_ channel, carrying the status code and, when the frame is
// good, the link control and length bytes. Other bytes produce no output.
// A byte is registered on its transfer and processed by the CRC and check logic when the
// core takes it; out_valid rises when the core takes the last byte and its status is registered.
// One byte can be taken every cycle while in_ready is high; the CRC update is combinational.
// When the receiver stalls, bytes that are not last keep flowing; a last byte waits in
// the input register until the result register is free, and in_ready drops meanwhile.
// The cfg_ port writes the sync values and the length range one register at a time; it should
// be used only while no frame is in progress.
// Reset clears all frame state and both channel valid flags and restores the default
// configuration: sync bytes 0x05 and 0x64, length range 5 to 255.
module dnp3_link_frame_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_link_control,
  output logic [7:0] out_link_length,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_first_r;
  logic                 in_last_r;
  logic                 out_valid_r;
  dnp3lfc_pkg::result_t out_r;
  dnp3lfc_pkg::result_t result;
  dnp3lfc_pkg::cfg_t    cfg;
  logic                 advance;

  assign advance  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_data_byte;
      in_first_r <= in_first_byte;
      in_last_r  <= in_last_byte;
    end
  end

  dnp3lfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dnp3lfc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (advance),
    .data_byte  (in_byte_r),
    .first_byte (in_first_r),
    .last_byte  (in_last_r),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_r.status;
  assign out_link_control = out_r.control;
  assign out_link_length  = out_r.length;

endmodule

FILE: rtl/dnp3lfc_checker.sv
// Port-level assertions for the DNP3 link frame checker and their bind to the top level.
module dnp3lfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_frame_status,
  input logic [7:0] out_link_control,
  input logic [7:0] out_link_length
);

  // A stalled status transfer keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status)
      && $stable(out_link_control) && $stable(out_link_length))
    else $error("status changed while stalled");

  // Captured header fields are reported only for a good frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != 3'(dnp3lfc_pkg::STATUS_OK)
      |-> out_link_control == 8'd0 && out_link_length == 8'd0)
    else $error("header fields shown on a failed frame");

  // With the result slot empty, the input side never stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending status");

  // Reset leaves no status pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("status pending after reset");

endmodule

bind dnp3_link_frame_checker_top dnp3lfc_checker u_checker (.*);

FILE: bench/dnp3_link_frame_checker_top_test.sv
// Self-checking testbench for the DNP3 link frame checker with random framed byte streams.
module dnp3_link_frame_checker_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POS_LIMIT   = 511;
  localparam int SEG_BYTES   = dnp3lfc_pkg::BLOCK_BYTES;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA6BC;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       eof;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic in_first_byte = 1'b0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_frame_status;
  logic [7:0] out_link_control;
  logic [7:0] out_link_length;
  logic cfg_we = 1'b0;
  dnp3lfc_pkg::reg_index_t cfg_index = dnp3lfc_pkg::REG_SYNC_FIRST;
  logic [7:0] cfg_data = 8'h00;

  dnp3_link_frame_checker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_link_control (out_link_control),
    .out_link_length  (out_link_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  dnp3lfc_pkg::cfg_t cfg_now = '{sync_first: 8'h05, sync_second: 8'h64,
                                 min_length: 8'd5, max_length: 8'd255};

  int          pos = 0;
  logic [15:0] crc_run = 16'h0000;
  logic [7:0]  crc_lo = 8'h00;
  logic [7:0]  len_q = 8'h00;
  logic [7:0]  ctl_q = 8'h00;
  bit          sync_bad, len_bad, hcrc_bad, dcrc_bad;

  dnp3lfc_pkg::result_t expected_status[$];
  byte_item_t           pending_bytes[$];
  logic [7:0]           frame_buf[$];
  byte_item_t           next_item;

  int  items_made = 0;
  int  frames_made = 0;
  int  failures = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  results_seen = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  function automatic void frame_add(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endfunction

  function automatic void queue_item(input byte_item_t it);
    pending_bytes.insert(pending_bytes.size(), it);
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY_REFL;
    end
    return c;
  endfunction

  function automatic int payload_len(input logic [7:0] l);
    return (l > 8'd5) ? int'(l) - 5 : 0;
  endfunction

  function automatic int wire_size(input logic [7:0] l);
    int d;
    d = payload_len(l);
    return 10 + d + 2 * ((d + SEG_BYTES - 1) / SEG_BYTES);
  endfunction

  function automatic int idle_len(input bit busy);
    int r;
    if (busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_frame();
    pos = 0;
    crc_run = 16'h0000;
    crc_lo = 8'h00;
    len_q = 8'h00;
    ctl_q = 8'h00;
    sync_bad = 1'b0;
    len_bad = 1'b0;
    hcrc_bad = 1'b0;
    dcrc_bad = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic sof, input logic eof);
    int q, k, r, d, used, blen;
    logic [15:0] want;
    dnp3lfc_pkg::status_t st;
    dnp3lfc_pkg::result_t res;
    if (sof) clear_frame();
    case (pos)
      0: if (b != cfg_now.sync_first) sync_bad = 1'b1;
      1: if (b != cfg_now.sync_second) sync_bad = 1'b1;
      2: begin
        len_q = b;
        if (b < cfg_now.min_length || b > cfg_now.max_length) len_bad = 1'b1;
      end
      3: ctl_q = b;
      default: ;
    endcase
    want = ~crc_run;
    if (pos < 8) begin
      crc_run = crc16_step(crc_run, b);
    end else if (pos == 8) begin
      crc_lo = b;
    end else if (pos == 9) begin
      if (want[7:0] != crc_lo || want[15:8] != b) hcrc_bad = 1'b1;
      crc_run = 16'h0000;
    end else if (pos < wire_size(len_q)) begin
      q = pos - 10;
      k = q / (SEG_BYTES + 2);
      r = q % (SEG_BYTES + 2);
      used = k * SEG_BYTES;
      d = payload_len(len_q);
      if (used < d) begin
        blen = (d - used > SEG_BYTES) ? SEG_BYTES : d - used;
        if (r < blen) begin
          crc_run = crc16_step(crc_run, b);
        end else if (r == blen) begin
          crc_lo = b;
        end else if (r == blen + 1) begin
          if (want[7:0] != crc_lo || want[15:8] != b) dcrc_bad = 1'b1;
          crc_run = 16'h0000;
        end
      end
    end
    if (pos < POS_LIMIT) pos++;
    if (eof) begin
      if (pos < 10) st = dnp3lfc_pkg::STATUS_SHORT;
      else if (sync_bad) st = dnp3lfc_pkg::STATUS_SYNC;
      else if (len_bad) st = dnp3lfc_pkg::STATUS_LENGTH;
      else if (pos < wire_size(len_q)) st = dnp3lfc_pkg::STATUS_TRUNCATED;
      else if (hcrc_bad) st = dnp3lfc_pkg::STATUS_HDR_CRC;
      else if (dcrc_bad) st = dnp3lfc_pkg::STATUS_DATA_CRC;
      else st = dnp3lfc_pkg::STATUS_OK;
      res.status = st;
      res.control = (st == dnp3lfc_pkg::STATUS_OK) ? ctl_q : 8'h00;
      res.length = (st == dnp3lfc_pkg::STATUS_OK) ? len_q : 8'h00;
      expected_status.insert(expected_status.size(), res);
      clear_frame();
    end
  endtask

  task automatic build_frame(input logic [7:0] len);
    logic [15:0] c;
    logic [7:0] b;
    int d, blen;
    frame_buf.delete();
    frame_add(cfg_now.sync_first);
    frame_add(cfg_now.sync_second);
    frame_add(len);
    repeat (5) frame_add(8'($urandom));
    c = 16'h0000;
    for (int i = 0; i < 8; i++) c = crc16_step(c, frame_buf[i]);
    c = ~c;
    frame_add(c[7:0]);
    frame_add(c[15:8]);
    d = payload_len(len);
    while (d > 0) begin
      blen = (d > SEG_BYTES) ? SEG_BYTES : d;
      c = 16'h0000;
      repeat (blen) begin
        b = 8'($urandom);
        frame_add(b);
        c = crc16_step(c, b);
      end
      c = ~c;
      frame_add(c[7:0]);
      frame_add(c[15:8]);
      d -= blen;
    end
  endtask

  task automatic send_frame(input bit mark_start);
    foreach (frame_buf[i]) begin
      queue_item('{data: frame_buf[i], sof: mark_start && i == 0,
                   eof: i == frame_buf.size() - 1});
      items_made++;
    end
    frames_made++;
  endtask

  function automatic logic [7:0] pick_length();
    int lo, hi;
    lo = int'(cfg_now.min_length);
    hi = int'(cfg_now.max_length);
    if (lo > hi) begin
      lo = 5;
      hi = 255;
    end
    if ($urandom_range(0, 4) != 0 && hi > lo + 20) hi = lo + 20;
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic make_random_frame();
    int kind, cut, at;
    bit mark_start;
    kind = $urandom_range(0, 99);
    mark_start = ($urandom_range(0, 4) != 0);
    build_frame(pick_length());
    if (kind < 50) begin
    end else if (kind < 65) begin
      at = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[at] ^= 8'(1 << $urandom_range(0, 7));
    end else if (kind < 75) begin
      cut = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 6)) frame_add(8'($urandom));
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 12)) begin
        queue_item('{data: 8'($urandom), sof: 1'b0, eof: 1'b0});
        items_made++;
      end
      mark_start = 1'b1;
    end else if (kind < 94) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 9)) frame_add(8'($urandom));
    end else begin
      build_frame($urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom));
    end
    send_frame(mark_start);
  endtask

  task automatic fill_random(input int budget);
    int start;
    start = items_made;
    while (items_made - start < budget) make_random_frame();
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input dnp3lfc_pkg::reg_index_t idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic load_config(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] mn, input logic [7:0] mx);
    write_reg(dnp3lfc_pkg::REG_SYNC_FIRST, s1);
    write_reg(dnp3lfc_pkg::REG_SYNC_SECOND, s2);
    write_reg(dnp3lfc_pkg::REG_MIN_LENGTH, mn);
    write_reg(dnp3lfc_pkg::REG_MAX_LENGTH, mx);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_now = '{sync_first: s1, sync_second: s2, min_length: mn, max_length: mx};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) absorb_byte(in_data_byte, in_first_byte, in_last_byte);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data;
          in_first_byte <= next_item.sof;
          in_last_byte <= next_item.eof;
          send_gap = idle_len(send_burst);
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    dnp3lfc_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen == 6) hold_left = 400;
        if (expected_status.size() == 0) begin
          $error("unexpected transfer: frame_status %0d", out_frame_status);
          failures++;
        end else begin
          want = expected_status.pop_front();
          if (out_frame_status !== want.status) begin
            $error("frame_status: expected %0d, actual %0d", want.status, out_frame_status);
            failures++;
          end
          if (out_link_control !== want.control) begin
            $error("link_control: expected %0d, actual %0d", want.control, out_link_control);
            failures++;
          end
          if (out_link_length !== want.length) begin
            $error("link_length: expected %0d, actual %0d", want.length, out_link_length);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_len(recv_burst);
        if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("dnp3_link_frame_checker_top test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] mn;
    clear_frame();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    build_frame(8'd5);
    send_frame(1'b0);
    queue_item('{data: 8'($urandom), sof: 1'b1, eof: 1'b1});
    items_made++;
    frames_made++;
    build_frame(8'd6);
    send_frame(1'b1);

    fill_random(100);
    settle();

    load_config(8'h00, 8'hFF, 8'd5, 8'd5);
    fill_random(60);
    settle();

    load_config(8'hFF, 8'h00, 8'd255, 8'd255);
    build_frame(8'd255);
    repeat (230) frame_add(8'($urandom));
    send_frame(1'b1);
    settle();

    load_config(8'($urandom), 8'($urandom), 8'd200, 8'd100);
    fill_random(40);
    settle();

    mn = 8'($urandom_range(5, 40));
    load_config(8'($urandom), 8'($urandom), mn, 8'($urandom_range(mn, 255)));
    fill_random(100);
    settle();

    load_config(8'h05, 8'h64, 8'd5, 8'd255);
    while (items_made < 950 || frames_made < 50) make_random_frame();
    settle();
    repeat (6) @(posedge clk);

    if (failures == 0) begin
      $display("dnp3_link_frame_checker_top test passed");
    end else begin
      $display("dnp3_link_frame_checker_top test failed");
    end
    $finish;
  end

endmodule
